/* rtl/core/frp_pkg.sv */
// Package for the flash erase range planner.
// Holds shared widths, opcodes, status codes and the command struct.
// No dependencies.
`timescale 1ns / 1ps

package frp_pkg;

  // Fixed field widths.
  localparam int unsigned AddrW     = 21;
  localparam int unsigned LenW      = 22;
  localparam int unsigned OpcodeW   = 8;
  localparam int unsigned StatusW   = 2;

  // Sector geometry; all sequencing arithmetic runs in 4K sector units.
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned SectorShift  = 12;
  localparam int unsigned BlockUnits   = 16;   // 64K block in sectors
  localparam int unsigned ThreshUnits  = 32;   // 128K threshold in sectors

  // Unit-domain width: holds start plus rounded length in sectors.
  localparam int unsigned UnitW = AddrW - SectorShift + 2;

  // Default flash size.
  localparam int unsigned FLASH_BYTES_DEF = 2097152;

  // Erase opcodes.
  localparam logic [OpcodeW-1:0] OpSector = 8'h20;
  localparam logic [OpcodeW-1:0] OpBlock  = 8'hD8;
  localparam logic [OpcodeW-1:0] OpNone   = 8'h00;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StCommand    = 2'd0,
    StMisaligned = 2'd1,
    StZeroLength = 2'd2,
    StBeyondEnd  = 2'd3
  } status_e;

  // One result from the sequencer to the output register.
  typedef struct packed {
    status_e              status;
    logic [OpcodeW-1:0]   opcode;
    logic [AddrW-1:0]     address;
    logic                 last;
  } cmd_t;

endpackage

/* rtl/core/frp_adder.sv */
// Shared adder of the erase range planner, used by the end, limit and emit steps.
// Depends on frp_pkg for the unit-domain width.
`timescale 1ns / 1ps

module frp_adder (
  input  logic [frp_pkg::UnitW-1:0] a_i,
  input  logic [frp_pkg::UnitW-1:0] b_i,
  input  logic                      cin_i,
  output logic [frp_pkg::UnitW-1:0] sum_o
);

  // Modular add with carry-in; subtraction is done by inverting b with cin set.
  assign sum_o = a_i + b_i + frp_pkg::UnitW'(cin_i);

endmodule

/* rtl/core/frp_ctrl.sv */
// Sequencer of the erase range planner: checks a request, then walks the
// range in sector units through the shared adder. Depends on frp_pkg, frp_adder.
`timescale 1ns / 1ps

module frp_ctrl #(
  parameter int unsigned FLASH_BYTES = frp_pkg::FLASH_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [frp_pkg::AddrW-1:0]  start_address_i,
  input  logic [frp_pkg::LenW-1:0]   byte_length_i,
  input  logic                       out_free_i,
  output logic                       cmd_valid_o,
  output frp_pkg::cmd_t              cmd_o
);

  localparam int unsigned UW = frp_pkg::UnitW;
  localparam int unsigned SS = frp_pkg::SectorShift;
  localparam logic [UW-1:0] FLASH_UNITS = UW'(FLASH_BYTES / frp_pkg::SECTOR_BYTES);
  localparam logic [UW-1:0] BLOCK_U     = UW'(frp_pkg::BlockUnits);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_END    = 5'b00010,
    S_LIMIT  = 5'b00100,
    S_EMIT   = 5'b01000,
    S_REPORT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [frp_pkg::AddrW-1:0] start_q;
  logic [frp_pkg::LenW-1:0]  len_q;
  logic [UW-1:0]             end_q;
  logic [UW-1:0]             lim_q;
  logic [UW-1:0]             cur_q;
  logic                      blk_q;
  frp_pkg::status_e          err_q;

  logic [UW-1:0] add_a, add_b, add_sum;
  logic          add_cin;
  logic          len_frac;
  logic          is_block;
  logic          is_last;

  assign len_frac = |len_q[SS-1:0];
  assign is_block = blk_q && (cur_q[3:0] == 4'd0) && (cur_q <= lim_q);
  assign is_last  = (add_sum == end_q);

  // Operand selection for the shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      S_END: begin
        add_a   = UW'(start_q[frp_pkg::AddrW-1:SS]);
        add_b   = UW'(len_q[frp_pkg::LenW-1:SS]);
        add_cin = len_frac;
      end
      S_LIMIT: begin
        add_a   = end_q;
        add_b   = ~BLOCK_U;
        add_cin = 1'b1;
      end
      S_EMIT: begin
        add_a   = cur_q;
        add_b   = is_block ? BLOCK_U : UW'(1);
        add_cin = 1'b0;
      end
      default: begin
      end
    endcase
  end

  frp_adder u_adder (
    .a_i   (add_a),
    .b_i   (add_b),
    .cin_i (add_cin),
    .sum_o (add_sum)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_END;
      S_END: begin
        if (start_q[SS-1:0] != '0 || len_q == '0) state_d = S_REPORT;
        else                                      state_d = S_LIMIT;
      end
      S_LIMIT: begin
        if (end_q > FLASH_UNITS) state_d = S_REPORT;
        else                     state_d = S_EMIT;
      end
      S_EMIT:   if (out_free_i && is_last) state_d = S_IDLE;
      S_REPORT: if (out_free_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the request being worked on.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        start_q <= start_address_i;
        len_q   <= byte_length_i;
      end
      S_END: begin
        end_q <= add_sum;
        // Rounded length reaches 128K when the length exceeds 31 sectors.
        blk_q <= (len_q[frp_pkg::LenW-1:SS+5] != '0)
                 || ((&len_q[SS+4:SS]) && len_frac);
        if (start_q[SS-1:0] != '0) err_q <= frp_pkg::StMisaligned;
        else                       err_q <= frp_pkg::StZeroLength;
      end
      S_LIMIT: begin
        lim_q <= add_sum;
        cur_q <= UW'(start_q[frp_pkg::AddrW-1:SS]);
        err_q <= frp_pkg::StBeyondEnd;
      end
      S_EMIT: begin
        if (out_free_i) cur_q <= add_sum;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Result toward the output register.
  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (state_q == S_EMIT) begin
      cmd_valid_o    = out_free_i;
      cmd_o.status   = frp_pkg::StCommand;
      cmd_o.opcode   = is_block ? frp_pkg::OpBlock : frp_pkg::OpSector;
      cmd_o.address  = {cur_q[frp_pkg::AddrW-SS-1:0], {SS{1'b0}}};
      cmd_o.last     = is_last;
    end else if (state_q == S_REPORT) begin
      cmd_valid_o    = out_free_i;
      cmd_o.status   = err_q;
      cmd_o.opcode   = frp_pkg::OpNone;
      cmd_o.address  = '0;
      cmd_o.last     = 1'b1;
    end
  end

endmodule

/* rtl/core/flash_erase_range_planner.sv */
// Top level of the flash erase range planner: sequencer plus output register.
// Depends on frp_pkg and frp_ctrl.
`timescale 1ns / 1ps

// Splits one erase request into SPI NOR erase commands, one result per
// transaction on the output channel, in rising address order. A request is
// taken only while the block is idle. A request with a misaligned start, a
// zero length or a range past FLASH_BYTES gives one error result; the first
// two are found in the end step, the last in the limit step. A good request
// passes both steps and then emits one command per cycle through the shared
// adder while the output register is free, at most 60 commands in all. An
// output stall holds emission. The next request is taken while the final
// result still waits in the output register.
module flash_erase_range_planner #(
  parameter int unsigned FLASH_BYTES = frp_pkg::FLASH_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [frp_pkg::AddrW-1:0]     start_address_i,
  input  logic [frp_pkg::LenW-1:0]      byte_length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [frp_pkg::StatusW-1:0]   status_o,
  output logic [frp_pkg::OpcodeW-1:0]   erase_opcode_o,
  output logic [frp_pkg::AddrW-1:0]     erase_address_o,
  output logic                          last_command_o
);

  logic          out_valid_q;
  frp_pkg::cmd_t out_q;
  logic          out_free;
  logic          cmd_valid;
  frp_pkg::cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  frp_ctrl #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_address_i (start_address_i),
    .byte_length_i   (byte_length_i),
    .out_free_i      (out_free),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_valid) begin
      out_q <= cmd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign erase_opcode_o  = out_q.opcode;
  assign erase_address_o = out_q.address;
  assign last_command_o  = out_q.last;

endmodule

/* rtl/core/frp_checker.sv */
// Port-level checker for the flash erase range planner, with its bind.
// Depends on frp_pkg and the top-level flash_erase_range_planner.
`timescale 1ns / 1ps

module frp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [frp_pkg::StatusW-1:0] status_o,
  input logic [frp_pkg::OpcodeW-1:0] erase_opcode_o,
  input logic [frp_pkg::AddrW-1:0]   erase_address_o,
  input logic                        last_command_o
);

  // An error result is a single, fixed, final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != frp_pkg::StCommand) |->
      erase_opcode_o == frp_pkg::OpNone && erase_address_o == '0 && last_command_o)
    else $error("error result carries a command or is not last");

  // A command is a sector or a block erase on a matching boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == frp_pkg::StCommand) |->
      (erase_opcode_o == frp_pkg::OpSector && erase_address_o[11:0] == '0) ||
      (erase_opcode_o == frp_pkg::OpBlock && erase_address_o[15:0] == '0))
    else $error("bad opcode or unaligned erase address");

  // Once a request is taken the block works on it before taking another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while busy");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(erase_opcode_o) && $stable(erase_address_o) && $stable(last_command_o))
    else $error("stalled result changed");

endmodule

bind flash_erase_range_planner frp_checker u_frp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .erase_opcode_o  (erase_opcode_o),
  .erase_address_o (erase_address_o),
  .last_command_o  (last_command_o)
);

/* test/flash_erase_range_planner_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for flash_erase_range_planner: erase requests in, erase commands out.
// It predicts every command from the request and checks it against the output channel.
// Depends on frp_pkg and the flash_erase_range_planner RTL.

module flash_erase_range_planner_tb;

  localparam int unsigned FlashBytes     = frp_pkg::FLASH_BYTES_DEF;
  localparam int unsigned SectorBytes    = frp_pkg::SECTOR_BYTES;
  localparam int unsigned BlockBytes     = 32'h10000;
  localparam int unsigned BlockThreshold = 2 * BlockBytes;
  localparam int          CmdLimit       = 60;
  localparam int          RandomItems    = 280;
  localparam int          DrainCycles    = 80;
  localparam int          CycleLimit     = 1_600_000;
  localparam int          MaxReports     = 10;

  typedef logic [frp_pkg::AddrW-1:0] addr_t;
  typedef logic [frp_pkg::LenW-1:0]  len_t;

  typedef struct {
    addr_t start;
    len_t  length;
  } erase_req_t;

  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  addr_t                         start_address_i = '0;
  len_t                          byte_length_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic [frp_pkg::StatusW-1:0]   status_o;
  logic [frp_pkg::OpcodeW-1:0]   erase_opcode_o;
  addr_t                         erase_address_o;
  logic                          last_command_o;

  erase_req_t    req_backlog[$];
  frp_pkg::cmd_t erase_cmds_due[$];
  int            reqs_total    = 0;
  int            reqs_accepted = 0;
  int            mismatches    = 0;
  int            cycles        = 0;
  int            send_gap      = 0;
  int            recv_stall    = 0;
  bit            no_idle       = 1'b0;

  flash_erase_range_planner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_address_i (start_address_i),
    .byte_length_i   (byte_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .erase_opcode_o  (erase_opcode_o),
    .erase_address_o (erase_address_o),
    .last_command_o  (last_command_o)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic void add_req(input addr_t start, input len_t length);
    erase_req_t r;
    r.start  = start;
    r.length = length;
    req_backlog.push_back(r);
    reqs_total++;
  endfunction

  // Appends one expected command unless the per-request command cap is reached.
  function automatic void add_cmd(inout int n, input frp_pkg::status_e st,
                                  input logic [frp_pkg::OpcodeW-1:0] op,
                                  input int unsigned addr);
    frp_pkg::cmd_t c;
    if (n >= CmdLimit) return;
    c.status  = st;
    c.opcode  = op;
    c.address = addr[frp_pkg::AddrW-1:0];
    c.last    = 1'b0;
    erase_cmds_due.push_back(c);
    n++;
  endfunction

  // Splits one request into the erase commands it must produce.
  function automatic void plan_erase(input addr_t start_a, input len_t len_b);
    int unsigned begin_addr, span, stop_addr, cur, head_end, body_end, a;
    int          n;
    begin_addr = 32'(start_a);
    span       = 32'(len_b);
    n          = 0;
    if (begin_addr % SectorBytes != 0) begin
      add_cmd(n, frp_pkg::StMisaligned, frp_pkg::OpNone, 0);
    end else if (span == 0) begin
      add_cmd(n, frp_pkg::StZeroLength, frp_pkg::OpNone, 0);
    end else begin
      span      = (span + SectorBytes - 1) / SectorBytes * SectorBytes;
      stop_addr = begin_addr + span;
      if (stop_addr > FlashBytes) begin
        add_cmd(n, frp_pkg::StBeyondEnd, frp_pkg::OpNone, 0);
      end else if (span >= BlockThreshold) begin
        // Sectors up to the next 64K boundary, whole blocks, then the sector tail.
        cur      = begin_addr;
        head_end = (begin_addr + BlockBytes - 1) / BlockBytes * BlockBytes;
        body_end = stop_addr / BlockBytes * BlockBytes;
        if (cur < head_end && head_end <= stop_addr) begin
          for (a = cur; a < head_end; a += SectorBytes)
            add_cmd(n, frp_pkg::StCommand, frp_pkg::OpSector, a);
          cur = head_end;
        end
        if (cur < body_end) begin
          for (a = cur; a < body_end; a += BlockBytes)
            add_cmd(n, frp_pkg::StCommand, frp_pkg::OpBlock, a);
          cur = body_end;
        end
        for (a = cur; a < stop_addr; a += SectorBytes)
          add_cmd(n, frp_pkg::StCommand, frp_pkg::OpSector, a);
      end else begin
        for (a = begin_addr; a < stop_addr; a += SectorBytes)
          add_cmd(n, frp_pkg::StCommand, frp_pkg::OpSector, a);
      end
    end
    if (n > 0) erase_cmds_due[erase_cmds_due.size() - 1].last = 1'b1;
  endfunction

  // Request driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      start_address_i <= '0;
      byte_length_i   <= '0;
      send_gap        <= 0;
    end else begin : drive_req
      erase_req_t nr;
      if (in_valid_i && in_ready_o) begin
        plan_erase(start_address_i, byte_length_i);
        reqs_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (req_backlog.size() > 0) begin
          nr = req_backlog.pop_front();
          in_valid_i      <= 1'b1;
          start_address_i <= nr.start;
          byte_length_i   <= nr.length;
          send_gap        <= idle_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Command monitor: checks every output transaction and applies random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
    end else begin : take_cmd
      frp_pkg::cmd_t exp_cmd;
      int            g;
      if (out_valid_o && out_ready_i) begin
        if (erase_cmds_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected erase command: status %0d opcode %h address %h last %b",
                     status_o, erase_opcode_o, erase_address_o, last_command_o);
        end else begin
          exp_cmd = erase_cmds_due.pop_front();
          if (status_o !== exp_cmd.status || erase_opcode_o !== exp_cmd.opcode ||
              erase_address_o !== exp_cmd.address || last_command_o !== exp_cmd.last) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display({"erase command mismatch: expected status %0d opcode %h ",
                        "address %h last %b, got status %0d opcode %h address %h last %b"},
                       exp_cmd.status, exp_cmd.opcode, exp_cmd.address, exp_cmd.last,
                       status_o, erase_opcode_o, erase_address_o, last_command_o);
          end
        end
      end
      if (recv_stall > 0) begin
        out_ready_i <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else if (!out_valid_o || out_ready_i) begin
        g = idle_gap();
        out_ready_i <= (g == 0);
        recv_stall  <= (g > 0) ? g - 1 : 0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Cycle counter, idle-free stretches and the timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 400 == 0) no_idle <= ($urandom_range(0, 3) == 0);
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** flash_erase_range_planner: FAILED **");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin : stimulus
    int          i, kind;
    int unsigned len_u, nsec, sec;

    // Directed requests: every error, both opcodes and the size boundaries.
    add_req(21'h000001, 22'h001000);      // misaligned start
    add_req(21'h1FFFFF, 22'h000000);      // misaligned wins over zero length
    add_req(21'h000800, 22'h001000);      // misaligned by one bit only
    add_req(21'h000000, 22'h000000);      // zero length
    add_req(21'h000000, 22'h000001);      // one byte rounds up to one sector
    add_req(21'h000000, 22'h001000);
    add_req(21'h000000, 22'h001001);
    add_req(21'h000000, 22'h01F000);      // largest sector-only run
    add_req(21'h000000, 22'h01FFFF);      // rounds up onto the block threshold
    add_req(21'h001000, 22'h020000);      // sector head, one block, sector tail
    add_req(21'h010000, 22'h020000);      // exactly two blocks
    add_req(21'h00F000, 22'h022000);
    add_req(21'h000000, 22'h200000);      // whole flash
    add_req(21'h001000, 22'h1FE000);      // the longest command run
    add_req(21'h1F0000, 22'h010000);
    add_req(21'h1FF000, 22'h001000);      // top sector
    add_req(21'h1FF000, 22'h001001);      // one byte past the end
    add_req(21'h000000, 22'h200001);
    add_req(21'h000000, 22'h3FFFFF);
    add_req(21'h1FF000, 22'h200000);
    add_req(21'h100000, 22'h3FF000);

    // Random requests, mostly well formed with random sizes and placement.
    for (i = 0; i < RandomItems; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        add_req(addr_t'($urandom_range(0, 21'h1FFFFF)), len_t'($urandom_range(0, 22'h3FFFFF)));
      end else if (kind < 12) begin
        add_req(addr_t'(($urandom_range(0, 511) << 12) | $urandom_range(1, 4095)),
                len_t'($urandom_range(0, 22'h3FFFFF)));
      end else if (kind < 14) begin
        add_req(addr_t'($urandom_range(0, 511) << 12), '0);
      end else if (kind < 92) begin
        if (kind < 70) len_u = $urandom_range(1, BlockThreshold - 1);
        else len_u = $urandom_range(BlockThreshold, FlashBytes);
        nsec = (len_u + SectorBytes - 1) / SectorBytes;
        sec  = $urandom_range(0, FlashBytes / SectorBytes - nsec);
        add_req(addr_t'(sec * SectorBytes), len_t'(len_u));
      end else begin
        sec   = $urandom_range(0, 511);
        len_u = FlashBytes - sec * SectorBytes + $urandom_range(1, 8192);
        add_req(addr_t'(sec * SectorBytes), len_t'(len_u));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every command has come out.
    while (reqs_accepted < reqs_total || erase_cmds_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && erase_cmds_due.size() == 0) begin
      $display("** flash_erase_range_planner: PASSED **");
    end else begin
      $display("** flash_erase_range_planner: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/frp_pkg.sv
rtl/core/frp_adder.sv
rtl/core/frp_ctrl.sv
rtl/core/flash_erase_range_planner.sv
rtl/core/frp_checker.sv
test/flash_erase_range_planner_tb.sv
